[hdl/kbsf_pkg.sv]
// Shared types, status codes and the set-1 scan-code translation table.
`timescale 1ns / 1ps

package kbsf_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_DROPPED = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // Input item kinds.
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam int SCAN_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int FILL_W  = 8;
    localparam int OUT_DW  = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the input item
        logic execute;  // translate, push or pop, and load the result
    } t_ctl_cmd;

    // Set-1 make code (bit 7 already stripped) to ASCII; zero means unmapped.
    function automatic logic [CHAR_W-1:0] scan_to_ascii(input logic [6:0] code);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        unique case (code)
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;
            7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08;  // backspace
            7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;
            7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;
            7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;
            7'h1A: ch = 7'h5B;
            7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;  // enter gives line feed
            7'h1E: ch = 7'h61;
            7'h1F: ch = 7'h73;
            7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A;
            7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C;
            7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h7A;
            7'h2D: ch = 7'h78;
            7'h2E: ch = 7'h63;
            7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62;
            7'h31: ch = 7'h6E;
            7'h32: ch = 7'h6D;
            7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E;
            7'h35: ch = 7'h2F;
            7'h39: ch = 7'h20;  // space bar
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

[hdl/kbsf_ctrl.sv]
// Controller state machine: accept, execute and present one item at a time.
`timescale 1ns / 1ps

module kbsf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output kbsf_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEND
    } t_state;

    t_state r_state;
    logic   r_s_tready;
    logic   r_m_tvalid;
    logic   accept;

    assign accept = i_s_tvalid & r_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s_tready <= 1'b1;
            r_m_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state    <= S_EXEC;
                        r_s_tready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state    <= S_SEND;
                    r_m_tvalid <= 1'b1;
                end
                S_SEND: begin
                    if (i_m_tready) begin
                        r_state    <= S_IDLE;
                        r_m_tvalid <= 1'b0;
                        r_s_tready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_s_tready <= 1'b1;
                    r_m_tvalid <= 1'b0;
                end
            endcase
        end
    end

    assign o_cmd.capture = accept;
    assign o_cmd.execute = (r_state == S_EXEC);
    assign o_s_tready    = r_s_tready;
    assign o_m_tvalid    = r_m_tvalid;

endmodule

[hdl/kbsf_datapath.sv]
// Datapath: item latch, scan-code translation, ring buffer memory and result register.
`timescale 1ns / 1ps

module kbsf_datapath #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kbsf_pkg::t_ctl_cmd                   i_cmd,
    input  logic                                 i_mode,
    input  logic [kbsf_pkg::SCAN_W-1:0]          i_key_code,
    output logic [kbsf_pkg::CHAR_W-1:0]          o_char_code,
    output kbsf_pkg::t_status                    o_status,
    output logic [kbsf_pkg::FILL_W-1:0]          o_fill_count
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

    logic [kbsf_pkg::CHAR_W-1:0] r_mem [FIFO_DEPTH];
    logic [kbsf_pkg::CHAR_W-1:0] r_rd_data;

    logic                          r_mode;
    logic [kbsf_pkg::SCAN_W-1:0]   r_code;
    logic [AW-1:0]                 r_wr_idx;
    logic [AW-1:0]                 r_rd_idx;
    logic [kbsf_pkg::CHAR_W-1:0]   r_char;
    kbsf_pkg::t_status             r_status;
    logic [kbsf_pkg::FILL_W-1:0]   r_fill;

    logic [kbsf_pkg::CHAR_W-1:0]   ascii;
    logic [AW-1:0]                 wr_inc;
    logic [AW-1:0]                 rd_inc;
    logic [AW-1:0]                 n_wr_idx;
    logic [AW-1:0]                 n_rd_idx;
    logic                          do_push;
    logic [kbsf_pkg::CHAR_W-1:0]   n_char;
    kbsf_pkg::t_status             n_status;
    logic [CW-1:0]                 held;

    assign ascii  = kbsf_pkg::scan_to_ascii(r_code[6:0]);
    assign wr_inc = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + AW'(1);
    assign rd_inc = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + AW'(1);

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        do_push  = 1'b0;
        n_char   = '0;
        n_status = kbsf_pkg::ST_OK;
        if (r_mode == kbsf_pkg::MODE_SCAN) begin
            if (r_code[7] || (ascii == '0)) begin
                n_status = kbsf_pkg::ST_IGNORED;
            end else if (wr_inc == r_rd_idx) begin
                // Keep one slot free: drop the character but report it.
                n_char   = ascii;
                n_status = kbsf_pkg::ST_DROPPED;
            end else begin
                n_char   = ascii;
                do_push  = 1'b1;
                n_wr_idx = wr_inc;
            end
        end else begin
            if (r_rd_idx == r_wr_idx) begin
                n_status = kbsf_pkg::ST_EMPTY;
            end else begin
                n_char   = r_rd_data;
                n_rd_idx = rd_inc;
            end
        end
    end

    // Occupancy after the update, wrapped onto the ring.
    always_comb begin
        held = {1'b0, n_wr_idx} - {1'b0, n_rd_idx};
        if (n_wr_idx < n_rd_idx) begin
            held = held + CW'(FIFO_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && do_push) begin
            r_mem[r_wr_idx] <= ascii;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
        end else if (i_cmd.execute) begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_code <= i_key_code;
        end
        if (i_cmd.execute) begin
            r_char   <= n_char;
            r_status <= n_status;
            r_fill   <= kbsf_pkg::FILL_W'(held);
        end
    end

    assign o_char_code  = r_char;
    assign o_status     = r_status;
    assign o_fill_count = r_fill;

endmodule

[hdl/keyboard_scancode_fifo_unit.sv]
// Top level of the keyboard scan-code FIFO: controller plus datapath.
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                        tuser
// -------   ---------  ----------------------------------------  -----------
// s (in)    to block   key_code[7:0]                             mode[0]
// m (out)   from block char_code[6:0], fill_count[14:7], 0 [15]  status[1:0]
//
// Each transfer in produces exactly one transfer out. The item is latched at
// its input transfer, the execute state follows against the single-write-port
// character memory (its registered read is fetched ahead) and registers the
// result, which is shown in the send state and held while the output side
// stalls; input ready rises again the cycle after the result is taken, so the
// block takes one item at a time.
// Reset (i_rst_n low, synchronous) empties the ring buffer by clearing its
// indices; the memory itself is not cleared and no clearing pass is needed.

module keyboard_scancode_fifo_unit #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // key_code[7:0]
    input  logic                          i_s_tuser,   // mode[0]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [kbsf_pkg::OUT_DW-1:0]   o_m_tdata,   // char_code[6:0], fill_count[14:7], zero[15]
    output logic [1:0]                    o_m_tuser    // status[1:0]
);

    kbsf_pkg::t_ctl_cmd                cmd;
    logic [kbsf_pkg::CHAR_W-1:0]       char_code;
    kbsf_pkg::t_status                 status;
    logic [kbsf_pkg::FILL_W-1:0]       fill_count;

    // Sequence each item: hold input ready low until its result is taken.
    kbsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // Translate, push or pop, and hold the result stable while stalled.
    kbsf_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_s_tuser),
        .i_key_code   (i_s_tdata),
        .o_char_code  (char_code),
        .o_status     (status),
        .o_fill_count (fill_count)
    );

    // Pack the result: character lowest, then occupancy, pad to whole bytes.
    assign o_m_tdata = {1'b0, fill_count, char_code};
    assign o_m_tuser = status;

endmodule

[hdl/kbsf_checker.sv]
// Port-level checks of the keyboard scan-code FIFO and their binding.
`timescale 1ns / 1ps

module kbsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result changed while stalled");

    // One item in flight: never ready for input while a result is shown.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while result pending");

    // Input transfer closes the input side on the next cycle.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input still ready after transfer");

    // A read on an empty buffer reports no character and nothing held.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == kbsf_pkg::ST_EMPTY)) |-> (o_m_tdata == 16'h0000))
        else $error("empty read with data");

    // An ignored code gives no character.
    a_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == kbsf_pkg::ST_IGNORED)) |-> (o_m_tdata[6:0] == 7'h00))
        else $error("ignored code with character");

endmodule

bind keyboard_scancode_fifo_unit kbsf_checker u_kbsf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
